// File: hw/rtl/fpss_pkg.sv
// Package for the five-point stencil sweep: shared constants, register codes and the
// per-item tag that travels down the stencil pipeline.
// No dependencies.
package fpss_pkg;

  localparam int unsigned DEF_MAX_COLS     = 1024;
  localparam int unsigned DEF_MAX_ROWS     = 1024;
  localparam int unsigned DEF_SAMPLE_WIDTH = 32;

  localparam int unsigned CFG_DIM_W   = 11;  // rows_in_use / cols_in_use
  localparam int unsigned COEF_W      = 16;  // unsigned Q0.16
  localparam int unsigned CFG_DATA_W  = 16;  // widest register
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned COORD_W     = 10;  // row / column result fields
  localparam int unsigned MIN_DIM     = 3;

  localparam logic [CFG_DIM_W-1:0] RESET_ROWS = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] RESET_COLS = 11'd1024;
  localparam logic [COEF_W-1:0]    RESET_COEF = 16'd13107;

  // Result queue: four items in flight (one entering, three in the pipe), three results each
  localparam int unsigned FIFO_DEPTH   = 16;
  localparam int unsigned FIFO_RESERVE = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_COEF = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               emit_diag;   // cell one row up, one column left
    logic               emit_right;  // cell one row up, same column (last column)
    logic               emit_own;    // this cell (last row)
    logic               interior;    // diagonal cell takes the stencil
    logic               frame_end;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } fpss_tag_t;

endpackage

// File: hw/rtl/fpss_line_mem.sv
// Two line buffers (upper and middle row) in synchronous single-port-per-side memories.
// Depends on nothing; registered read.
module fpss_line_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_upper,
  output logic [DATA_W-1:0] rd_middle,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_upper,
  input  logic [DATA_W-1:0] wr_middle
);

  logic [DATA_W-1:0] upper_mem  [DEPTH];
  logic [DATA_W-1:0] middle_mem [DEPTH];
  logic [DATA_W-1:0] rd_upper_r;
  logic [DATA_W-1:0] rd_middle_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r  <= upper_mem[rd_addr];
      rd_middle_r <= middle_mem[rd_addr];
    end
  end

  assign rd_upper  = rd_upper_r;
  assign rd_middle = rd_middle_r;

endmodule

// File: hw/rtl/fpss_core.sv
// Stencil datapath: window registers, line-buffer write-back, five-point sum,
// coefficient multiply, rounding and saturation, result formatting.
// Depends on fpss_pkg.
module fpss_core #(
  parameter int unsigned SW      = 32,
  parameter int unsigned ADDR_W  = 10,
  parameter int unsigned ENTRY_W = 2 * fpss_pkg::COORD_W + SW + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  fpss_pkg::fpss_tag_t         acc_tag,
  input  logic [SW-1:0]               acc_sample,
  input  logic [ADDR_W-1:0]           acc_addr,
  input  logic [fpss_pkg::COEF_W-1:0] coef,
  input  logic [SW-1:0]               rd_upper,
  input  logic [SW-1:0]               rd_middle,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [SW-1:0]               wr_upper,
  output logic [SW-1:0]               wr_middle,
  output logic [2:0]                  push_vld,
  output logic [ENTRY_W-1:0]          push_data [3]
);
  import fpss_pkg::*;

  localparam int unsigned SUM_W  = SW + 3;
  localparam int unsigned PROD_W = SUM_W + COEF_W + 1;
  localparam int unsigned RND_W  = PROD_W - COEF_W;

  // stage B: memory data arrives
  logic                b_vld_r;
  fpss_tag_t           b_tag_r;
  logic signed [SW-1:0] b_smp_r;
  logic [ADDR_W-1:0]   b_addr_r;

  logic signed [SW-1:0] win_left_r, win_mid_r, win_up_r, prev_r;
  logic signed [SW-1:0] mid_c, up_c;
  logic signed [SUM_W-1:0] b_sum;

  // stage C: sum held, multiply
  logic                    c_vld_r;
  fpss_tag_t               c_tag_r;
  logic signed [SUM_W-1:0] c_sum_r;
  logic [SW-1:0]           c_pass_r, c_right_r, c_own_r;
  logic signed [PROD_W-1:0] c_prod;

  // stage D: product held, round and saturate
  logic                     d_vld_r;
  fpss_tag_t                d_tag_r;
  logic signed [PROD_W-1:0] d_prod_r;
  logic [SW-1:0]            d_pass_r, d_right_r, d_own_r;
  logic signed [PROD_W-1:0] d_biased;
  logic signed [RND_W-1:0]  d_rnd;
  logic [SW-1:0]            d_sat, d_diag_val;
  logic                     d_fits;
  logic                     last_diag, last_right;

  assign mid_c = $signed(rd_middle);
  assign up_c  = $signed(rd_upper);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_tag_r  <= acc_tag;
      b_smp_r  <= $signed(acc_sample);
      b_addr_r <= acc_addr;
    end
  end

  // Consecutive items sit in different columns, so this write never meets the read
  // issued in the same cycle.
  assign wr_en     = b_vld_r;
  assign wr_addr   = b_addr_r;
  assign wr_upper  = rd_middle;
  assign wr_middle = b_smp_r;

  assign b_sum = SUM_W'(win_left_r) + SUM_W'(win_mid_r) + SUM_W'(mid_c)
               + SUM_W'(win_up_r) + SUM_W'(prev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r <= '0;
      win_mid_r  <= '0;
      win_up_r   <= '0;
      prev_r     <= '0;
    end else if (b_vld_r) begin
      win_left_r <= win_mid_r;
      win_mid_r  <= mid_c;
      win_up_r   <= up_c;
      prev_r     <= b_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  assign c_prod = PROD_W'(c_sum_r) * $signed({1'b0, coef});

  always_ff @(posedge clk) begin
    c_tag_r   <= b_tag_r;
    c_sum_r   <= b_sum;
    c_pass_r  <= win_mid_r;
    c_right_r <= rd_middle;
    c_own_r   <= b_smp_r;
    d_tag_r   <= c_tag_r;
    d_prod_r  <= c_prod;
    d_pass_r  <= c_pass_r;
    d_right_r <= c_right_r;
    d_own_r   <= c_own_r;
  end

  // round half up, then clip to the sample range
  assign d_biased = d_prod_r + PROD_W'(1 << (COEF_W - 1));
  assign d_rnd    = RND_W'(d_biased >>> COEF_W);
  assign d_fits   = (d_rnd[RND_W-1:SW-1] == '0) || (d_rnd[RND_W-1:SW-1] == '1);

  always_comb begin
    if (d_fits) begin
      d_sat = d_rnd[SW-1:0];
    end else if (d_rnd[RND_W-1]) begin
      d_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      d_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign d_diag_val = d_tag_r.interior ? d_sat : d_pass_r;
  assign last_diag  = !d_tag_r.emit_right && !d_tag_r.emit_own;
  assign last_right = !d_tag_r.emit_own;

  assign push_vld = {d_vld_r && d_tag_r.emit_own,
                     d_vld_r && d_tag_r.emit_right,
                     d_vld_r && d_tag_r.emit_diag};

  // entry layout from the lowest bit: row, column, value, last, frame done
  assign push_data[0] = {1'b0, last_diag, d_diag_val,
                         d_tag_r.col - COORD_W'(1), d_tag_r.row - COORD_W'(1)};
  assign push_data[1] = {d_tag_r.frame_end && last_right, last_right, d_right_r,
                         d_tag_r.col, d_tag_r.row - COORD_W'(1)};
  assign push_data[2] = {d_tag_r.frame_end, 1'b1, d_own_r, d_tag_r.col, d_tag_r.row};

endmodule

// File: hw/rtl/fpss_out_fifo.sv
// Result queue taking up to three entries a cycle, popped one a cycle.
// Depends on fpss_pkg for nothing but is sized by its users.
module fpss_out_fifo #(
  parameter int unsigned DATA_W = 54,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned PTR_W  = $clog2(DEPTH),
  parameter int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        push_vld,
  input  logic [DATA_W-1:0] push_data [3],
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head_data,
  output logic [CNT_W-1:0]  count
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  slot [3];
  logic [1:0]        push_n;

  // pack the present entries together in order
  assign slot[0] = tail_r;
  assign slot[1] = tail_r + PTR_W'(push_vld[0]);
  assign slot[2] = tail_r + PTR_W'(push_vld[0]) + PTR_W'(push_vld[1]);
  assign push_n  = 2'(push_vld[0]) + 2'(push_vld[1]) + 2'(push_vld[2]);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (push_vld[k]) begin
        mem_r[slot[k]] <= push_data[k];
      end
    end
  end

  assign count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_r + PTR_W'(pop);
      tail_r  <= tail_r + PTR_W'(push_n);
      count_r <= count_nxt;
    end
  end

  assign not_empty = (count_r != '0);
  assign head_data = mem_r[head_r];
  assign count     = count_r;

endmodule

// File: hw/rtl/five_point_stencil_sweep.sv
// Five-point stencil sweep: one Jacobi pass over a raster-order grid.
// Throughput: one sample transaction per cycle while in_tready is high; results leave at
// one per cycle while out_tready is high. A sample's first result passes the line-buffer
// read, sum and multiply registers and rounding; its other results follow one a cycle.
// in_tready drops only while the result queue holds more than four results.
// rst_n (synchronous): counters, window and queue cleared, registers to reset values.
module five_point_stencil_sweep #(
  parameter int unsigned MAX_COLS     = fpss_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS     = fpss_pkg::DEF_MAX_ROWS,
  parameter int unsigned SAMPLE_WIDTH = fpss_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // sample stream
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]    in_tdata,  // sample
  // result stream
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // row, column, value
  output logic [((2 * fpss_pkg::COORD_W + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                                         out_tlast,  // last_in_run
  output logic                                         out_tuser,  // frame_done
  // register writes
  input  logic                                         cfg_we,
  input  logic [fpss_pkg::CFG_INDEX_W-1:0]             cfg_index,
  input  logic [fpss_pkg::CFG_DATA_W-1:0]              cfg_wdata
);
  import fpss_pkg::*;

  localparam int unsigned SW         = SAMPLE_WIDTH;
  localparam int unsigned OUT_DATA_W = ((2 * COORD_W + SW + 7) / 8) * 8;
  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  localparam int unsigned ENTRY_W    = 2 * COORD_W + SW + 2;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [CFG_DIM_W-1:0] rows_r, cols_r;
  logic [COEF_W-1:0]    coef_r;

  // raster position of the next sample
  logic [ROW_W-1:0] row_r, row_nxt, row_last;
  logic [COL_W-1:0] col_r, col_nxt, col_last;
  logic             last_col, last_row;

  logic             acc;
  fpss_tag_t        acc_tag;
  logic [SW-1:0]    sample;

  logic [SW-1:0]    rd_upper, rd_middle;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [SW-1:0]    wr_upper, wr_middle;

  logic [2:0]         push_vld;
  logic [ENTRY_W-1:0] push_data [3];
  logic [ENTRY_W-1:0] head_data;
  logic [CNT_W-1:0]   fifo_count;

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RESET_ROWS;
      cols_r <= RESET_COLS;
      coef_r <= RESET_COEF;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS: rows_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_COLS: cols_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_COEF: coef_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size into [3, MAX] and hold it as the last index.
  always_comb begin
    if (rows_r < CFG_DIM_W'(MIN_DIM)) begin
      row_last = ROW_W'(MIN_DIM - 1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      row_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      row_last = ROW_W'(rows_r - CFG_DIM_W'(1));
    end
    if (cols_r < CFG_DIM_W'(MIN_DIM)) begin
      col_last = COL_W'(MIN_DIM - 1);
    end else if (32'(cols_r) > MAX_COLS) begin
      col_last = COL_W'(MAX_COLS - 1);
    end else begin
      col_last = COL_W'(cols_r - CFG_DIM_W'(1));
    end
  end

  // A counter left beyond a shrunken size counts as being at the last index.
  assign last_col = (col_r >= col_last);
  assign last_row = (row_r >= row_last);

  // Accept only while the queue can absorb the worst case of every item in flight.
  assign in_tready = (fifo_count <= CNT_W'(FIFO_DEPTH - FIFO_RESERVE));
  assign acc       = in_tvalid && in_tready;
  assign sample    = in_tdata[SW-1:0];

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Decide what this transaction emits; the first row emits nothing.
  always_comb begin
    acc_tag.emit_diag  = (row_r != '0) && (col_r != '0);
    acc_tag.emit_right = (row_r != '0) && last_col;
    acc_tag.emit_own   = (row_r != '0) && last_row;
    // diagonal cell (row-1, col-1) is interior when 2 <= row <= last and 2 <= col <= last
    acc_tag.interior   = (row_r >= ROW_W'(2)) && (row_r <= row_last)
                      && (col_r >= COL_W'(2)) && (col_r <= col_last);
    acc_tag.frame_end  = last_row && last_col;
    acc_tag.row        = COORD_W'(row_r);
    acc_tag.col        = COORD_W'(col_r);
  end

  // Line buffers: read the column on the transaction, write it back in the next cycle.
  fpss_line_mem #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_W),
    .DATA_W (SW)
  ) u_line_mem (
    .clk       (clk),
    .rd_en     (acc),
    .rd_addr   (col_r),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_upper  (wr_upper),
    .wr_middle (wr_middle)
  );

  fpss_core #(
    .SW      (SW),
    .ADDR_W  (COL_W),
    .ENTRY_W (ENTRY_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .acc_tag    (acc_tag),
    .acc_sample (sample),
    .acc_addr   (col_r),
    .coef       (coef_r),
    .rd_upper   (rd_upper),
    .rd_middle  (rd_middle),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_upper   (wr_upper),
    .wr_middle  (wr_middle),
    .push_vld   (push_vld),
    .push_data  (push_data)
  );

  // Output skid: results wait here so the sample side keeps moving.
  fpss_out_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_data (push_data),
    .pop       (out_tvalid && out_tready),
    .not_empty (out_tvalid),
    .head_data (head_data),
    .count     (fifo_count)
  );

  assign out_tdata = OUT_DATA_W'(head_data[2 * COORD_W + SW - 1:0]);
  assign out_tlast = head_data[2 * COORD_W + SW];
  assign out_tuser = head_data[2 * COORD_W + SW + 1];

endmodule
